// ===== hdl/scl_pkg.sv =====
// shell command lexer package: word types, lexer state codes and byte classes
// used by scl_lexer, scl_result_buf and shell_command_lexer
// no dependencies
`default_nettype none

package scl_pkg;

  // result kinds
  typedef enum logic [1:0] {
    KIND_CHAR = 2'd0,
    KIND_END  = 2'd1,
    KIND_DONE = 2'd2
  } kind_e;

  // input word
  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_input;
  } in_t;

  // result word
  typedef struct packed {
    logic [7:0] out_byte;
    kind_e      kind;
    logic       last_of_run;
  } out_t;

  localparam int unsigned RunMax = 3;

  // all results caused by one input word
  typedef struct packed {
    logic [1:0]        count;
    out_t [RunMax-1:0] item;
  } run_t;

  // quote modes
  localparam logic [1:0] QM_NONE   = 2'd0;
  localparam logic [1:0] QM_SINGLE = 2'd1;
  localparam logic [1:0] QM_DOUBLE = 2'd2;

  // operator lookahead modes
  localparam logic [1:0] OPM_NONE   = 2'd0;
  localparam logic [1:0] OPM_FIRST  = 2'd1;
  localparam logic [1:0] OPM_AMP    = 2'd2;
  localparam logic [1:0] OPM_DIGITS = 2'd3;

  // pending operator codes
  localparam logic [2:0] OP_NONE = 3'd0;
  localparam logic [2:0] OP_AMP  = 3'd1;
  localparam logic [2:0] OP_PIPE = 3'd2;
  localparam logic [2:0] OP_LT   = 3'd3;
  localparam logic [2:0] OP_GT   = 3'd4;

  // character constants
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_PIPE   = 8'h7c;
  localparam logic [7:0] CH_SEMI   = 8'h3b;
  localparam logic [7:0] CH_LT     = 8'h3c;
  localparam logic [7:0] CH_GT     = 8'h3e;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_DASH   = 8'h2d;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0d;

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= CH_ZERO) && (b <= CH_NINE);
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
  endfunction

  function automatic logic [2:0] op_code(input logic [7:0] b);
    logic [2:0] code;
    unique case (b)
      CH_AMP:  code = OP_AMP;
      CH_PIPE: code = OP_PIPE;
      CH_LT:   code = OP_LT;
      CH_GT:   code = OP_GT;
      default: code = OP_NONE;
    endcase
    return code;
  endfunction

  function automatic logic [7:0] op_char(input logic [2:0] code);
    logic [7:0] ch;
    unique case (code)
      OP_AMP:  ch = CH_AMP;
      OP_PIPE: ch = CH_PIPE;
      OP_LT:   ch = CH_LT;
      OP_GT:   ch = CH_GT;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic out_t mk_result(input logic [7:0] b, input kind_e k);
    out_t res;
    res.out_byte    = b;
    res.kind        = k;
    res.last_of_run = 1'b0;
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/shell_command_lexer.sv =====
// Shell command lexer: one command-line byte (or an end-of-input mark) per
// input word; emits token characters, end-of-token marks and a finish mark.
// Flow: an accepted word is registered in the input register and lexed from
// there. Its results (zero to three) are loaded into a result buffer once the
// buffer is free, and the first result is then on the output. A new word is
// taken every cycle as long as each word gives at most one result and the
// output does not stall; a word that gives more results holds the input port
// until they have left, and the result buffer sets that rate. Words that give no result do not occupy the buffer.
// depends on scl_pkg, scl_lexer, scl_result_buf
`default_nettype none

module shell_command_lexer
  import scl_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  input  wire in_t  in_word_i,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output out_t      out_word_o
);

  logic in_valid_q;
  in_t  in_word_q;
  logic free;
  logic fire;
  logic in_take;
  run_t run;

  // input register advances when the result buffer can take its run
  assign fire       = in_valid_q && free;
  assign in_stall_o = in_valid_q && !free;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_word_q <= in_word_i;
    end
  end

  // lexer step
  scl_lexer u_lexer (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .word_i (in_word_q),
    .run_o  (run)
  );

  // result buffer
  scl_result_buf u_result_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (fire),
    .run_i       (run),
    .free_o      (free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

`default_nettype wire

// ===== hdl/scl_lexer.sv =====
// lexer step logic and lexer state registers
// depends on scl_pkg
`default_nettype none

module scl_lexer
  import scl_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic fire_i,
  input  wire in_t  word_i,
  output run_t      run_o
);

  logic       token_open_q, token_open_d;
  logic [1:0] quote_mode_q, quote_mode_d;
  logic       escape_q, escape_d;
  logic       all_digits_q, all_digits_d;
  logic [1:0] op_mode_q, op_mode_d;
  logic [2:0] pend_op_q, pend_op_d;

  logic [7:0] b;
  logic [7:0] first;
  logic       redir;
  logic       used;
  logic       joins;
  logic [1:0] n;
  out_t [RunMax-1:0] res;

  // one lexer step: results and next state
  always_comb begin
    token_open_d = token_open_q;
    quote_mode_d = quote_mode_q;
    escape_d     = escape_q;
    all_digits_d = all_digits_q;
    op_mode_d    = op_mode_q;
    pend_op_d    = pend_op_q;
    b            = word_i.in_byte;
    first        = op_char(pend_op_q);
    redir        = (pend_op_q == OP_LT) || (pend_op_q == OP_GT);
    used         = 1'b0;
    joins        = 1'b0;
    n            = 2'd0;
    res          = '0;

    if (word_i.end_of_input) begin
      // flush open token, report finish, back to reset state
      if (token_open_d) begin
        res[n] = mk_result(8'h00, KIND_END);
        n = n + 2'd1;
      end
      res[n] = mk_result(8'h00, KIND_DONE);
      n = n + 2'd1;
      token_open_d = 1'b0;
      quote_mode_d = QM_NONE;
      escape_d     = 1'b0;
      all_digits_d = 1'b1;
      op_mode_d    = OPM_NONE;
      pend_op_d    = OP_NONE;
    end else begin
      // operator lookahead on the raw byte
      if (op_mode_d != OPM_NONE) begin
        unique case (op_mode_d)
          OPM_FIRST: begin
            if ((pend_op_d != OP_NONE) && (b == first)) begin
              res[n] = mk_result(b, KIND_CHAR);
              n = n + 2'd1;
              if (!is_digit(b)) all_digits_d = 1'b0;
              res[n] = mk_result(8'h00, KIND_END);
              n = n + 2'd1;
              token_open_d = 1'b0;
              all_digits_d = 1'b1;
              op_mode_d    = OPM_NONE;
              pend_op_d    = OP_NONE;
              used = 1'b1;
            end else if (redir && (b == CH_AMP)) begin
              res[n] = mk_result(b, KIND_CHAR);
              n = n + 2'd1;
              all_digits_d = 1'b0;
              op_mode_d = OPM_AMP;
              used = 1'b1;
            end
          end
          OPM_AMP: begin
            if (b == CH_DASH) begin
              res[n] = mk_result(b, KIND_CHAR);
              n = n + 2'd1;
              all_digits_d = 1'b0;
              res[n] = mk_result(8'h00, KIND_END);
              n = n + 2'd1;
              token_open_d = 1'b0;
              all_digits_d = 1'b1;
              op_mode_d    = OPM_NONE;
              pend_op_d    = OP_NONE;
              used = 1'b1;
            end else if (is_digit(b)) begin
              res[n] = mk_result(b, KIND_CHAR);
              n = n + 2'd1;
              op_mode_d = OPM_DIGITS;
              used = 1'b1;
            end
          end
          default: begin
            if (is_digit(b)) begin
              res[n] = mk_result(b, KIND_CHAR);
              n = n + 2'd1;
              used = 1'b1;
            end
          end
        endcase
        // operator not extended: close it, then lex the byte normally
        if (!used) begin
          res[n] = mk_result(8'h00, KIND_END);
          n = n + 2'd1;
          token_open_d = 1'b0;
          all_digits_d = 1'b1;
          op_mode_d    = OPM_NONE;
          pend_op_d    = OP_NONE;
        end
      end

      // plain lexing of the byte
      if (!used) begin
        if (escape_d) begin
          if (!token_open_d) begin
            token_open_d = 1'b1;
            all_digits_d = 1'b1;
          end
          res[n] = mk_result(b, KIND_CHAR);
          n = n + 2'd1;
          if (!is_digit(b)) all_digits_d = 1'b0;
          escape_d = 1'b0;
        end else if ((b == CH_BSLASH) && (quote_mode_d != QM_SINGLE)) begin
          escape_d = 1'b1;
          if (!token_open_d) begin
            token_open_d = 1'b1;
            all_digits_d = 1'b1;
          end
        end else if (quote_mode_d != QM_NONE) begin
          res[n] = mk_result(b, KIND_CHAR);
          n = n + 2'd1;
          all_digits_d = 1'b0;
          if (((quote_mode_d == QM_SINGLE) && (b == CH_SQUOTE)) ||
              ((quote_mode_d == QM_DOUBLE) && (b == CH_DQUOTE))) begin
            quote_mode_d = QM_NONE;
          end
        end else if ((b == CH_SQUOTE) || (b == CH_DQUOTE)) begin
          quote_mode_d = (b == CH_SQUOTE) ? QM_SINGLE : QM_DOUBLE;
          token_open_d = 1'b1;
          res[n] = mk_result(b, KIND_CHAR);
          n = n + 2'd1;
          all_digits_d = 1'b0;
        end else if ((b == CH_SEMI) || (op_code(b) != OP_NONE)) begin
          // digit-only token followed by a redirect keeps it as a prefix
          joins = token_open_d && ((b == CH_LT) || (b == CH_GT)) && all_digits_d;
          if (token_open_d && !joins) begin
            res[n] = mk_result(8'h00, KIND_END);
            n = n + 2'd1;
            token_open_d = 1'b0;
            all_digits_d = 1'b1;
            op_mode_d    = OPM_NONE;
            pend_op_d    = OP_NONE;
          end
          token_open_d = 1'b1;
          res[n] = mk_result(b, KIND_CHAR);
          n = n + 2'd1;
          all_digits_d = 1'b0;
          if (b == CH_SEMI) begin
            res[n] = mk_result(8'h00, KIND_END);
            n = n + 2'd1;
            token_open_d = 1'b0;
            all_digits_d = 1'b1;
            op_mode_d    = OPM_NONE;
            pend_op_d    = OP_NONE;
          end else begin
            op_mode_d = OPM_FIRST;
            pend_op_d = op_code(b);
          end
        end else if (is_space(b)) begin
          if (token_open_d) begin
            res[n] = mk_result(8'h00, KIND_END);
            n = n + 2'd1;
            token_open_d = 1'b0;
            all_digits_d = 1'b1;
            op_mode_d    = OPM_NONE;
            pend_op_d    = OP_NONE;
          end
        end else begin
          if (!token_open_d) begin
            token_open_d = 1'b1;
            all_digits_d = 1'b1;
          end
          res[n] = mk_result(b, KIND_CHAR);
          n = n + 2'd1;
          if (!is_digit(b)) all_digits_d = 1'b0;
        end
      end
    end

    // flag the final result of the run
    if (n != 2'd0) begin
      res[n - 2'd1].last_of_run = 1'b1;
    end
  end

  assign run_o.count = n;
  assign run_o.item  = res;

  // lexer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      token_open_q <= 1'b0;
      quote_mode_q <= QM_NONE;
      escape_q     <= 1'b0;
      all_digits_q <= 1'b1;
      op_mode_q    <= OPM_NONE;
      pend_op_q    <= OP_NONE;
    end else if (fire_i) begin
      token_open_q <= token_open_d;
      quote_mode_q <= quote_mode_d;
      escape_q     <= escape_d;
      all_digits_q <= all_digits_d;
      op_mode_q    <= op_mode_d;
      pend_op_q    <= pend_op_d;
    end
  end

  // end of input always reports finish last
  a_eoi_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && word_i.end_of_input |->
      (run_o.count != 2'd0) && (run_o.item[run_o.count - 2'd1].kind == KIND_DONE))
    else $error("end of input without finish result");

  // an operator lookahead is always tied to an open token
  a_op_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_mode_q != OPM_NONE) |-> token_open_q && (pend_op_q != OP_NONE))
    else $error("operator lookahead without open token");

  // a quote or escape is only pending inside an open token
  a_quote_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (quote_mode_q != QM_NONE) || escape_q |-> token_open_q)
    else $error("quote or escape pending with no token");

endmodule

`default_nettype wire

// ===== hdl/scl_result_buf.sv =====
// result buffer: holds the run of one input word and hands out one word a cycle while the output does not stall
// depends on scl_pkg
`default_nettype none

module scl_result_buf
  import scl_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic load_i,
  input  wire run_t run_i,
  output logic      free_o,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output out_t      out_word_o
);

  out_t [RunMax-1:0] slot_q;
  logic [1:0]        cnt_q;
  logic              pop;

  assign out_valid_o = (cnt_q != 2'd0);
  assign out_word_o  = slot_q[0];
  assign pop         = out_valid_o && !out_stall_i;
  // room for a new run once the last held word leaves
  assign free_o      = (cnt_q == 2'd0) || (pop && (cnt_q == 2'd1));

  // count of held words
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else if (load_i) begin
      cnt_q <= run_i.count;
    end else if (pop) begin
      cnt_q <= cnt_q - 2'd1;
    end
  end

  // held words, head at slot 0
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      slot_q <= run_i.item;
    end else if (pop) begin
      slot_q[0] <= slot_q[1];
      slot_q[1] <= slot_q[2];
    end
  end

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> free_o)
    else $error("run loaded over held words");

  a_last_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd1) |-> out_word_o.last_of_run)
    else $error("final held word not flagged last");

  a_last_multi: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q > 2'd1) |-> !out_word_o.last_of_run)
    else $error("last flag before end of run");

endmodule

`default_nettype wire
